// File: sv/clhm_pkg.sv
package clhm_pkg;

  localparam int unsigned ERR_W     = 8;
  localparam int unsigned SUM_W     = 14;
  localparam int unsigned FILL_W    = 6;
  localparam int unsigned RUN_W     = 16;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned AVG_WINDOW_DEF = 10;

  localparam logic [ERR_W-1:0]  LOW_ERROR_LIMIT_RST = 8'd10;
  localparam logic [ERR_W-1:0]  DEGRADED_LIMIT_RST  = 8'd50;
  localparam logic [ERR_W-1:0]  FAIL_LIMIT_RST      = 8'd100;
  localparam logic [RUN_W-1:0]  SILENT_SAMPLES_RST  = 16'd50;
  localparam logic [RUN_W-1:0]  CONFIRM_SAMPLES_RST = 16'd3;
  localparam logic [TIME_W-1:0] TIMEOUT_MS_RST      = 32'd5000;

  typedef enum logic [2:0] {
    LINK_UNKNOWN      = 3'd0,
    LINK_CONNECTED    = 3'd1,
    LINK_DISCONNECTED = 3'd2,
    LINK_DEGRADED     = 3'd3,
    LINK_SILENT       = 3'd4
  } link_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_ERROR_LIMIT = 3'd0,
    REG_DEGRADED_LIMIT  = 3'd1,
    REG_FAIL_LIMIT      = 3'd2,
    REG_SILENT_SAMPLES  = 3'd3,
    REG_CONFIRM_SAMPLES = 3'd4,
    REG_TIMEOUT_MS      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               status_valid;
    logic [ERR_W-1:0]   rx_errors;
    logic [ERR_W-1:0]   tx_errors;
    logic               bus_off;
    logic [COUNT_W-1:0] message_count;
    logic [TIME_W-1:0]  now_ms;
  } clhm_in_t;

  typedef struct packed {
    link_state_e      link_state;
    logic             connected_event;
    logic             rotate_event;
    logic [ERR_W-1:0] avg_rx_error;
    logic [ERR_W-1:0] avg_tx_error;
    logic             average_ready;
  } clhm_out_t;

  typedef struct packed {
    logic [ERR_W-1:0]  low_error_limit;
    logic [ERR_W-1:0]  degraded_limit;
    logic [ERR_W-1:0]  fail_limit;
    logic [RUN_W-1:0]  silent_samples;
    logic [RUN_W-1:0]  confirm_samples;
    logic [TIME_W-1:0] timeout_ms;
  } clhm_cfg_t;

  typedef struct packed {
    logic             ready;
    logic [ERR_W-1:0] avg_rx;
    logic [ERR_W-1:0] avg_tx;
  } clhm_avg_t;

endpackage

// File: sv/clhm_cfg_regs.sv
module clhm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [clhm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [clhm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output clhm_pkg::clhm_cfg_t                 cfg_o
);
  import clhm_pkg::*;

  clhm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_error_limit <= LOW_ERROR_LIMIT_RST;
      cfg_q.degraded_limit  <= DEGRADED_LIMIT_RST;
      cfg_q.fail_limit      <= FAIL_LIMIT_RST;
      cfg_q.silent_samples  <= SILENT_SAMPLES_RST;
      cfg_q.confirm_samples <= CONFIRM_SAMPLES_RST;
      cfg_q.timeout_ms      <= TIMEOUT_MS_RST;
    end else if (cfg_valid_i) begin
      // Indexes past the register list are dropped.
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LOW_ERROR_LIMIT: cfg_q.low_error_limit <= cfg_data_i[ERR_W-1:0];
        REG_DEGRADED_LIMIT:  cfg_q.degraded_limit  <= cfg_data_i[ERR_W-1:0];
        REG_FAIL_LIMIT:      cfg_q.fail_limit      <= cfg_data_i[ERR_W-1:0];
        REG_SILENT_SAMPLES:  cfg_q.silent_samples  <= cfg_data_i[RUN_W-1:0];
        REG_CONFIRM_SAMPLES: cfg_q.confirm_samples <= cfg_data_i[RUN_W-1:0];
        REG_TIMEOUT_MS:      cfg_q.timeout_ms      <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/clhm_window.sv
module clhm_window #(
  parameter int unsigned AVG_WINDOW = clhm_pkg::AVG_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          sample_i,
  input  logic [clhm_pkg::ERR_W-1:0]    rx_err_i,
  input  logic [clhm_pkg::ERR_W-1:0]    tx_err_i,
  output clhm_pkg::clhm_avg_t           avg_o
);
  import clhm_pkg::*;

  // The divisor is always the window length, so the quotient is a multiply by a
  // rounded-up reciprocal. A shift of SUM_W + clog2(window) is exact for every sum.
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(AVG_WINDOW);
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));

  logic [SUM_W-1:0]  rx_sum_q, rx_sum_d, tx_sum_q, tx_sum_d;
  logic [SUM_W-1:0]  rx_sum_new, tx_sum_new;
  logic [FILL_W-1:0] fill_q, fill_d, fill_new;
  logic [PROD_W-1:0] rx_prod, tx_prod;
  logic              close;

  always_comb begin
    rx_sum_new = rx_sum_q + (sample_i ? SUM_W'(rx_err_i) : '0);
    tx_sum_new = tx_sum_q + (sample_i ? SUM_W'(tx_err_i) : '0);
    fill_new   = fill_q + FILL_W'(sample_i);
    close      = fill_new >= FILL_W'(AVG_WINDOW);
    rx_prod    = PROD_W'(rx_sum_new) * PROD_W'(RECIP);
    tx_prod    = PROD_W'(tx_sum_new) * PROD_W'(RECIP);

    avg_o.ready  = close;
    avg_o.avg_rx = close ? rx_prod[RECIP_SHIFT +: ERR_W] : '0;
    avg_o.avg_tx = close ? tx_prod[RECIP_SHIFT +: ERR_W] : '0;

    rx_sum_d = close ? '0 : rx_sum_new;
    tx_sum_d = close ? '0 : tx_sum_new;
    fill_d   = close ? '0 : fill_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_sum_q <= '0;
      tx_sum_q <= '0;
      fill_q   <= '0;
    end else if (step_i) begin
      rx_sum_q <= rx_sum_d;
      tx_sum_q <= tx_sum_d;
      fill_q   <= fill_d;
    end
  end

  a_fill_below_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fill_q < FILL_W'(AVG_WINDOW))
    else $error("window fill reached the window length without closing");

endmodule

// File: sv/clhm_classifier.sv
module clhm_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            sample_i,
  input  logic                            bus_off_i,
  input  logic [clhm_pkg::COUNT_W-1:0]    message_count_i,
  input  logic [clhm_pkg::TIME_W-1:0]     now_ms_i,
  input  clhm_pkg::clhm_avg_t             avg_i,
  input  clhm_pkg::clhm_cfg_t             cfg_i,
  output clhm_pkg::link_state_e           link_state_o,
  output logic                            connected_event_o,
  output logic                            rotate_event_o
);
  import clhm_pkg::*;

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    return (v == '1) ? v : v + RUN_W'(1);
  endfunction

  link_state_e        state_q, state_d, proposal;
  logic [COUNT_W-1:0] last_count_q, last_count_d;
  logic [RUN_W-1:0]   conn_run_q, conn_run_d, disc_run_q, disc_run_d;
  logic               boff_seen_q, boff_seen_d;
  logic [TIME_W-1:0]  stamp_q, stamp_d, stamp_mid, elapsed;
  logic               msg, rx_low, tx_low, any_degraded, any_fail;

  always_comb begin
    boff_seen_d  = sample_i ? bus_off_i : boff_seen_q;
    msg          = message_count_i > last_count_q;
    last_count_d = msg ? message_count_i : last_count_q;
    conn_run_d   = msg ? sat_inc(conn_run_q) : '0;
    disc_run_d   = msg ? '0 : sat_inc(disc_run_q);

    rx_low       = avg_i.avg_rx < cfg_i.low_error_limit;
    tx_low       = avg_i.avg_tx < cfg_i.low_error_limit;
    any_degraded = (avg_i.avg_rx > cfg_i.degraded_limit) ||
                   (avg_i.avg_tx > cfg_i.degraded_limit);
    any_fail     = (avg_i.avg_rx > cfg_i.fail_limit) ||
                   (avg_i.avg_tx > cfg_i.fail_limit);

    proposal  = state_q;
    stamp_mid = stamp_q;
    priority if (boff_seen_d) begin
      proposal  = LINK_DISCONNECTED;
      stamp_mid = now_ms_i;
    end else if (msg) begin
      proposal  = (!(rx_low && tx_low) && any_degraded) ? LINK_DEGRADED : LINK_CONNECTED;
      stamp_mid = '0;
    end else begin
      // A stamp of zero means not armed, even when now_ms itself was zero.
      if (stamp_q == '0) begin
        stamp_mid = now_ms_i;
      end
      priority if (any_fail) begin
        proposal = LINK_DISCONNECTED;
      end else if (rx_low && tx_low) begin
        if (disc_run_d > cfg_i.silent_samples) begin
          proposal = LINK_SILENT;
        end
      end else begin
        proposal = LINK_UNKNOWN;
      end
    end

    // Entering connected or disconnected needs a confirmed run; other moves are immediate.
    state_d           = state_q;
    connected_event_o = 1'b0;
    if (proposal != state_q) begin
      priority if (proposal == LINK_CONNECTED) begin
        if (conn_run_d >= cfg_i.confirm_samples) begin
          state_d           = proposal;
          connected_event_o = 1'b1;
        end
      end else if (proposal == LINK_DISCONNECTED) begin
        if (disc_run_d >= cfg_i.confirm_samples) begin
          state_d = proposal;
        end
      end else begin
        state_d = proposal;
      end
    end

    elapsed        = now_ms_i - stamp_mid;
    rotate_event_o = (state_d == LINK_DISCONNECTED) && (stamp_mid != '0) &&
                     (elapsed > cfg_i.timeout_ms);
    stamp_d        = rotate_event_o ? '0 : stamp_mid;
  end

  assign link_state_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= LINK_UNKNOWN;
      last_count_q <= '0;
      conn_run_q   <= '0;
      disc_run_q   <= '0;
      boff_seen_q  <= 1'b0;
      stamp_q      <= '0;
    end else if (step_i) begin
      state_q      <= state_d;
      last_count_q <= last_count_d;
      conn_run_q   <= conn_run_d;
      disc_run_q   <= disc_run_d;
      boff_seen_q  <= boff_seen_d;
      stamp_q      <= stamp_d;
    end
  end

  a_rotate_clears_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
      step_i && rotate_event_o |=> stamp_q == '0 && state_q == LINK_DISCONNECTED)
    else $error("rotate pulse left the disconnect stamp armed");

  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
      conn_run_q == '0 || disc_run_q == '0)
    else $error("connect and disconnect runs are both nonzero");

endmodule

// File: sv/can_link_health_monitor.sv
// Channel   Direction  Handshake               Beat
// in        input      in_valid_i / in_stall_o  clhm_in_t, one health check
// out       output     out_valid_o / out_stall_i  clhm_out_t, one result per check
// cfg       input      cfg_valid_i / cfg_ready_o  register index and write data
//
// Each check passes through an input register and the update logic into the result
// register, and one check is taken per cycle while the input is not stalled.
// The link state, run counters and window sums update as a check leaves the input
// register. Reset clears them and the valid flags and loads the register defaults.
// A stalled result holds the result register; one more check may wait in the input
// register, after which the input stalls. Configuration writes are always ready.
module can_link_health_monitor #(
  parameter int unsigned AVG_WINDOW = clhm_pkg::AVG_WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  clhm_pkg::clhm_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output clhm_pkg::clhm_out_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [clhm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [clhm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import clhm_pkg::*;

  clhm_in_t    in_q;
  logic        in_valid_q;
  clhm_out_t   out_q, result;
  logic        out_valid_q;
  logic        out_free, advance, accept;
  clhm_cfg_t   cfg;
  clhm_avg_t   avg;
  link_state_e link_state;
  logic        conn_ev, rot_ev;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  clhm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  clhm_window #(.AVG_WINDOW(AVG_WINDOW)) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_q.status_valid),
    .rx_err_i (in_q.rx_errors),
    .tx_err_i (in_q.tx_errors),
    .avg_o    (avg)
  );

  clhm_classifier u_classifier (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .sample_i          (in_q.status_valid),
    .bus_off_i         (in_q.bus_off),
    .message_count_i   (in_q.message_count),
    .now_ms_i          (in_q.now_ms),
    .avg_i             (avg),
    .cfg_i             (cfg),
    .link_state_o      (link_state),
    .connected_event_o (conn_ev),
    .rotate_event_o    (rot_ev)
  );

  always_comb begin
    result.link_state      = link_state;
    result.connected_event = conn_ev;
    result.rotate_event    = rot_ev;
    result.avg_rx_error    = avg.avg_rx;
    result.avg_tx_error    = avg.avg_tx;
    result.average_ready   = avg.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept |=> in_valid_q)
    else $error("accepted beat did not land in the input register");

  a_advance_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      advance |=> out_valid_o)
    else $error("processed beat did not reach the result register");

endmodule

// File: tb/link_health_checker.sv
module link_health_checker #(
  parameter int unsigned AVG_WINDOW = clhm_pkg::AVG_WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  clhm_pkg::clhm_in_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  clhm_pkg::clhm_out_t             out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [clhm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [clhm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              failures_o,
  output int                              outstanding_o,
  output int                              compared_o,
  output logic [4:0]                      states_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import clhm_pkg::*;

  // Our own copy of the monitor's registers and state.
  clhm_cfg_t         regs;
  link_state_e       link_now;
  logic [COUNT_W-1:0] last_count;
  logic [RUN_W-1:0]  conn_run;
  logic [RUN_W-1:0]  disc_run;
  logic [SUM_W-1:0]  rx_sum;
  logic [SUM_W-1:0]  tx_sum;
  logic [FILL_W-1:0] fill;
  logic              boff_latch;
  logic [TIME_W-1:0] stamp;

  clhm_out_t pending_reports[$];
  int        mismatches = 0;
  int        compared = 0;

  assign failures_o = mismatches;
  assign compared_o = compared;

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 30) begin
      $display("%0t: mismatch on beat %0d, %s: got %0h, expected %0h",
               $realtime, compared, what, got, want);
    end
    mismatches++;
  endtask

  // Advances the link state by one health check and returns the report it causes.
  task automatic advance_link(input clhm_in_t chk, output clhm_out_t res);
    logic             new_msg;
    logic [ERR_W-1:0] avg_rx;
    logic [ERR_W-1:0] avg_tx;
    logic             closed;
    logic             conn_pulse;
    logic             rot_pulse;
    link_state_e      proposal;
    avg_rx = '0;
    avg_tx = '0;
    closed = 1'b0;
    conn_pulse = 1'b0;
    rot_pulse = 1'b0;

    if (chk.status_valid) begin
      rx_sum = rx_sum + SUM_W'(chk.rx_errors);
      tx_sum = tx_sum + SUM_W'(chk.tx_errors);
      boff_latch = chk.bus_off;
      fill = fill + 1'b1;
    end

    new_msg = chk.message_count > last_count;
    if (new_msg) begin
      last_count = chk.message_count;
      disc_run = '0;
      conn_run = bump(conn_run);
    end else begin
      conn_run = '0;
      disc_run = bump(disc_run);
    end

    if (fill >= AVG_WINDOW && fill != '0) begin
      avg_rx = ERR_W'(rx_sum / fill);
      avg_tx = ERR_W'(tx_sum / fill);
      rx_sum = '0;
      tx_sum = '0;
      fill = '0;
      closed = 1'b1;
    end

    // Averages are zero between windows, and the classification uses them as they are.
    proposal = link_now;
    if (boff_latch) begin
      proposal = LINK_DISCONNECTED;
      stamp = chk.now_ms;
    end else if (new_msg) begin
      if (avg_rx < regs.low_error_limit && avg_tx < regs.low_error_limit) begin
        proposal = LINK_CONNECTED;
      end else if (avg_rx > regs.degraded_limit || avg_tx > regs.degraded_limit) begin
        proposal = LINK_DEGRADED;
      end else begin
        proposal = LINK_CONNECTED;
      end
      stamp = '0;
    end else begin
      if (stamp == '0) stamp = chk.now_ms;
      if (avg_rx > regs.fail_limit || avg_tx > regs.fail_limit) begin
        proposal = LINK_DISCONNECTED;
      end else if (avg_rx < regs.low_error_limit && avg_tx < regs.low_error_limit) begin
        if (disc_run > regs.silent_samples) proposal = LINK_SILENT;
      end else begin
        proposal = LINK_UNKNOWN;
      end
    end

    if (proposal != link_now) begin
      if (proposal == LINK_CONNECTED) begin
        if (conn_run >= regs.confirm_samples) begin
          link_now = proposal;
          conn_pulse = 1'b1;
        end
      end else if (proposal == LINK_DISCONNECTED) begin
        if (disc_run >= regs.confirm_samples) link_now = proposal;
      end else begin
        link_now = proposal;
      end
    end

    // A stamp of zero means not armed; the elapsed time wraps at 32 bits.
    if (link_now == LINK_DISCONNECTED && stamp != '0 &&
        TIME_W'(chk.now_ms - stamp) > regs.timeout_ms) begin
      rot_pulse = 1'b1;
      stamp = '0;
    end

    res.link_state = link_now;
    res.connected_event = conn_pulse;
    res.rotate_event = rot_pulse;
    res.avg_rx_error = avg_rx;
    res.avg_tx_error = avg_tx;
    res.average_ready = closed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    clhm_out_t want;
    clhm_out_t got;
    if (!rst_ni) begin
      regs.low_error_limit = LOW_ERROR_LIMIT_RST;
      regs.degraded_limit = DEGRADED_LIMIT_RST;
      regs.fail_limit = FAIL_LIMIT_RST;
      regs.silent_samples = SILENT_SAMPLES_RST;
      regs.confirm_samples = CONFIRM_SAMPLES_RST;
      regs.timeout_ms = TIMEOUT_MS_RST;
      link_now = LINK_UNKNOWN;
      last_count = '0;
      conn_run = '0;
      disc_run = '0;
      rx_sum = '0;
      tx_sum = '0;
      fill = '0;
      boff_latch = 1'b0;
      stamp = '0;
      pending_reports.delete();
      outstanding_o <= 0;
      states_seen_o <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOW_ERROR_LIMIT: regs.low_error_limit = cfg_data_i[ERR_W-1:0];
          REG_DEGRADED_LIMIT:  regs.degraded_limit = cfg_data_i[ERR_W-1:0];
          REG_FAIL_LIMIT:      regs.fail_limit = cfg_data_i[ERR_W-1:0];
          REG_SILENT_SAMPLES:  regs.silent_samples = cfg_data_i[RUN_W-1:0];
          REG_CONFIRM_SAMPLES: regs.confirm_samples = cfg_data_i[RUN_W-1:0];
          REG_TIMEOUT_MS:      regs.timeout_ms = cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        advance_link(in_data_i, want);
        pending_reports.push_back(want);
        states_seen_o[want.link_state] <= 1'b1;
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (pending_reports.size() == 0) begin
          flag_mismatch("result beat with none expected", 32'(got), '0);
        end else begin
          want = pending_reports.pop_front();
          if (got.link_state !== want.link_state)
            flag_mismatch("link_state", 32'(got.link_state), 32'(want.link_state));
          if (got.connected_event !== want.connected_event)
            flag_mismatch("connected_event", 32'(got.connected_event),
                          32'(want.connected_event));
          if (got.rotate_event !== want.rotate_event)
            flag_mismatch("rotate_event", 32'(got.rotate_event), 32'(want.rotate_event));
          if (got.avg_rx_error !== want.avg_rx_error)
            flag_mismatch("avg_rx_error", 32'(got.avg_rx_error), 32'(want.avg_rx_error));
          if (got.avg_tx_error !== want.avg_tx_error)
            flag_mismatch("avg_tx_error", 32'(got.avg_tx_error), 32'(want.avg_tx_error));
          if (got.average_ready !== want.average_ready)
            flag_mismatch("average_ready", 32'(got.average_ready),
                          32'(want.average_ready));
        end
        compared++;
      end
      outstanding_o <= pending_reports.size();
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import clhm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 90;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {
    TR_HEALTHY,
    TR_NOISY,
    TR_QUIET,
    TR_FAILING,
    TR_BUSOFF,
    TR_JUNK
  } traffic_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  clhm_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  clhm_out_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int         failures;
  int         outstanding;
  int         compared;
  logic [4:0] states_seen;

  int unsigned       sim_cycles = 0;
  int unsigned       checks_sent = 0;
  int unsigned       settings_used = 1;
  int unsigned       burst_left = 0;
  logic              no_idle = 1'b0;
  logic              hold_out = 1'b0;
  logic [COUNT_W-1:0] msg_count;
  logic [TIME_W-1:0]  clock_ms;

  can_link_health_monitor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  link_health_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .compared_o    (compared),
    .states_seen_o (states_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    sim_cycles <= sim_cycles + 1;
    if (sim_cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               sim_cycles, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls per beat, and one long hold-off when asked.
  initial begin
    int unsigned stall_len;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = no_idle ? 0 : $urandom_range(0, 17);
      end
      for (int unsigned k = 0; k < stall_len; k++) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  function automatic clhm_in_t mk_check(input logic valid, input logic [ERR_W-1:0] rx,
                                        input logic [ERR_W-1:0] tx, input logic boff,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [TIME_W-1:0] now);
    clhm_in_t c;
    c.status_valid = valid;
    c.rx_errors = rx;
    c.tx_errors = tx;
    c.bus_off = boff;
    c.message_count = cnt;
    c.now_ms = now;
    return c;
  endfunction

  task automatic offer_check(input clhm_in_t chk);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = no_idle ? 0 : $urandom_range(0, 17);
    end
    for (int unsigned k = 0; k < gap; k++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= chk;
    do @(posedge clk_i); while (in_stall_o);
    checks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering checks and waits until every expected result is back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_traffic(input int unsigned n_items);
    traffic_e    mode;
    int unsigned seg_left;
    int unsigned pick;
    clhm_in_t    c;
    seg_left = 0;
    mode = TR_HEALTHY;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) mode = TR_HEALTHY;
        else if (pick < 45) mode = TR_NOISY;
        else if (pick < 65) mode = TR_QUIET;
        else if (pick < 75) mode = TR_FAILING;
        else if (pick < 87) mode = TR_BUSOFF;
        else mode = TR_JUNK;
        seg_left = $urandom_range(4, 40);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      seg_left--;

      c.status_valid = ($urandom_range(0, 9) != 0);
      c.bus_off = 1'b0;
      clock_ms = clock_ms + 100;
      case (mode)
        TR_HEALTHY: begin
          c.rx_errors = ERR_W'($urandom_range(0, 12));
          c.tx_errors = ERR_W'($urandom_range(0, 12));
          if ($urandom_range(0, 7) != 0) msg_count = msg_count + $urandom_range(1, 5);
        end
        TR_NOISY: begin
          c.status_valid = 1'b1;
          c.rx_errors = ERR_W'($urandom_range(0, 255));
          c.tx_errors = ERR_W'($urandom_range(0, 255));
          msg_count = msg_count + $urandom_range(1, 5);
        end
        TR_QUIET: begin
          c.rx_errors = ERR_W'($urandom_range(0, 12));
          c.tx_errors = ERR_W'($urandom_range(0, 12));
          clock_ms = clock_ms + $urandom_range(0, 500);
        end
        TR_FAILING: begin
          c.rx_errors = ERR_W'($urandom_range(90, 255));
          c.tx_errors = ERR_W'($urandom_range(0, 255));
        end
        TR_BUSOFF: begin
          c.rx_errors = ERR_W'($urandom_range(0, 255));
          c.tx_errors = ERR_W'($urandom_range(0, 255));
          c.bus_off = ($urandom_range(0, 3) != 0);
          clock_ms = clock_ms + $urandom_range(0, 500);
        end
        default: begin
          c.status_valid = ($urandom_range(0, 1) != 0);
          c.rx_errors = ERR_W'($urandom_range(0, 255));
          c.tx_errors = ERR_W'($urandom_range(0, 255));
          c.bus_off = ($urandom_range(0, 1) != 0);
        end
      endcase

      c.message_count = msg_count;
      c.now_ms = clock_ms;
      if (mode == TR_JUNK) begin
        // Counts that step back are ignored by the block; larger ones become the new base.
        if ($urandom_range(0, 1)) begin
          c.message_count = $urandom_range(0, msg_count);
        end else begin
          c.message_count = msg_count + $urandom_range(0, 3);
          msg_count = c.message_count;
        end
        if ($urandom_range(0, 1)) c.now_ms = $urandom();
      end
      offer_check(c);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    msg_count = '0;
    clock_ms = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed checks under the reset settings.
    no_idle = 1'b1;
    // No message at time zero leaves the disconnect stamp unarmed.
    offer_check(mk_check(1'b0, 8'd0, 8'd0, 1'b0, 32'd0, 32'd0));
    // A full window of maximum errors: connected first, then degraded at window close.
    for (int unsigned k = 1; k <= 10; k++)
      offer_check(mk_check(1'b1, 8'd255, 8'd255, 1'b0, k, 100 * k));
    no_idle = 1'b0;
    // A failed status read does not latch bus-off.
    offer_check(mk_check(1'b0, 8'd0, 8'd0, 1'b1, 32'd10, 32'd1100));
    for (int unsigned k = 0; k < 4; k++)
      offer_check(mk_check(1'b1, 8'd200, 8'd10, 1'b1, 32'd10, 1200 + 100 * k));
    // Bus-off at time zero loads a stamp that counts as unarmed.
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b1, 32'd10, 32'd0));
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'd10, 32'd2000));
    // Well past the timeout while disconnected: rotate.
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'd10, 32'd8000));
    // A count that goes down is no message.
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'd3, 32'd8100));
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'd100, 32'd8200));
    msg_count = 32'd100;
    clock_ms = 32'd10000;
    run_traffic(120);
    settle();

    // Lenient extreme: every average below 255 is clean, no confirmation, instant timeout.
    write_reg(REG_LOW_ERROR_LIMIT, 32'd255);
    write_reg(REG_DEGRADED_LIMIT, 32'd255);
    write_reg(REG_FAIL_LIMIT, 32'd255);
    write_reg(REG_SILENT_SAMPLES, 32'd0);
    write_reg(REG_CONFIRM_SAMPLES, 32'd0);
    write_reg(REG_TIMEOUT_MS, 32'd0);
    settings_used++;
    run_traffic(120);
    settle();

    // Strict extreme: nothing is clean, confirmation and timeout never reached.
    write_reg(REG_LOW_ERROR_LIMIT, 32'd0);
    write_reg(REG_DEGRADED_LIMIT, 32'd0);
    write_reg(REG_FAIL_LIMIT, 32'd0);
    write_reg(REG_SILENT_SAMPLES, 32'd65535);
    write_reg(REG_CONFIRM_SAMPLES, 32'd65535);
    write_reg(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
    settings_used++;
    run_traffic(120);
    settle();

    // Mid-range settings with junk in the unused upper data bits.
    write_reg(REG_LOW_ERROR_LIMIT, ($urandom() & 32'hFFFF_FF00) | $urandom_range(5, 40));
    write_reg(REG_DEGRADED_LIMIT, ($urandom() & 32'hFFFF_FF00) | $urandom_range(30, 120));
    write_reg(REG_FAIL_LIMIT, ($urandom() & 32'hFFFF_FF00) | $urandom_range(60, 200));
    write_reg(REG_SILENT_SAMPLES, ($urandom() & 32'hFFFF_0000) | $urandom_range(5, 30));
    write_reg(REG_CONFIRM_SAMPLES, ($urandom() & 32'hFFFF_0000) | $urandom_range(1, 6));
    write_reg(REG_TIMEOUT_MS, $urandom_range(200, 3000));
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    settings_used++;
    // Back-to-back beats against a long result hold-off fill the pipeline.
    hold_out = 1'b1;
    burst_left = 30;
    run_traffic(140);
    settle();

    // Reset limits with a 1500 ms timeout; clock and message count run up to their wrap.
    write_reg(REG_LOW_ERROR_LIMIT, 32'(LOW_ERROR_LIMIT_RST));
    write_reg(REG_DEGRADED_LIMIT, 32'(DEGRADED_LIMIT_RST));
    write_reg(REG_FAIL_LIMIT, 32'(FAIL_LIMIT_RST));
    write_reg(REG_SILENT_SAMPLES, 32'(SILENT_SAMPLES_RST));
    write_reg(REG_CONFIRM_SAMPLES, 32'(CONFIRM_SAMPLES_RST));
    write_reg(REG_TIMEOUT_MS, 32'd1500);
    settings_used++;
    clock_ms = 32'hFFFF_E000;
    msg_count = 32'hFFFF_FC00;
    run_traffic(130);
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'hFFFF_FFFF, clock_ms));
    offer_check(mk_check(1'b1, 8'd0, 8'd0, 1'b0, 32'd5, clock_ms + 100));
    settle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d health checks under %0d register settings; %0d results compared.",
             checks_sent, settings_used, compared);
    $display("Link states reached, one bit per state from unknown upward: %b.",
             states_seen);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found.", failures);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
